// File: src/vnfbm_pkg.sv
package vnfbm_pkg;

    localparam int COORD_W    = 32;
    localparam int NOISE_W    = 16;
    localparam int SEED_W     = 32;
    localparam int OCT_W      = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Width of the octave counter carried with each word (covers up to 31 octaves).
    localparam int OCTN_W = 5;

    // Width of one blended octave value.
    localparam int V_W = 26;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 4'd1;

    localparam logic [SEED_W-1:0] SEED_RESET   = 32'd4171;
    localparam logic [OCT_W-1:0]  OCTAVE_RESET = 4'd4;

    // Lattice hash constants.
    localparam logic [31:0] HASH_MUL_X  = 32'h8da6b343;
    localparam logic [31:0] HASH_MUL_Y  = 32'hd8163841;
    localparam logic [31:0] HASH_MUL_S  = 32'hcb1ab31f;
    localparam logic [31:0] HASH_MIX_A  = 32'h7feb352d;
    localparam logic [31:0] HASH_MIX_B  = 32'h846ca68b;
    localparam logic [31:0] SEED_STEP   = 32'd1013;
    localparam logic [22:0] HALF_SPAN   = 23'h7fffff;

    // 2.03 in Q16.
    localparam logic signed [18:0] GAIN_Q16 = 19'sd133038;

    // Control that travels with every word through the pipeline.
    typedef struct packed {
        logic              valid;
        logic [OCTN_W-1:0] octaves;
    } ctl_t;

endpackage

// File: src/vnfbm_coord_if.sv
interface vnfbm_coord_if;
    import vnfbm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

// File: src/vnfbm_noise_if.sv
interface vnfbm_noise_if;
    import vnfbm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [NOISE_W-1:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// File: src/vnfbm_cfg_if.sv
interface vnfbm_cfg_if;
    import vnfbm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/vnfbm_octave.sv
module vnfbm_octave #(
    parameter int OCT_IDX         = 0,
    parameter int COORD_FRAC_BITS = 16,
    parameter int ACC_W           = 35
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [vnfbm_pkg::SEED_W-1:0]  seed,
    input  vnfbm_pkg::ctl_t               ctl_i,
    input  logic [vnfbm_pkg::COORD_W-1:0] x_i,
    input  logic [vnfbm_pkg::COORD_W-1:0] y_i,
    input  logic signed [ACC_W-1:0]       acc_i,
    output vnfbm_pkg::ctl_t               ctl_o,
    output logic [vnfbm_pkg::COORD_W-1:0] x_o,
    output logic [vnfbm_pkg::COORD_W-1:0] y_o,
    output logic signed [ACC_W-1:0]       acc_o
);
    import vnfbm_pkg::*;

    localparam int F = COORD_FRAC_BITS;
    localparam logic [63:0] OFS_X_W = ((64'd717 << F) + 64'd50) / 64'd100;
    localparam logic [63:0] OFS_Y_W = ((64'd341 << F) + 64'd50) / 64'd100;
    localparam logic [31:0] OFFSET_X = OFS_X_W[31:0];
    localparam logic [31:0] OFFSET_Y = OFS_Y_W[31:0];
    localparam logic [63:0] SEED_OFS_W = 64'(OCT_IDX) * 64'd1013;
    localparam logic [31:0] SEED_OFS = SEED_OFS_W[31:0];

    // Stage 1: lattice cell, hash premix, squared fraction, remap product.
    ctl_t                     c1_reg, c1_next;
    logic [31:0]              h0_reg [4];
    logic [31:0]              h0_next [4];
    logic [15:0]              tx_reg, ty_reg, tx_next, ty_next;
    logic [31:0]              ttx_reg, tty_reg, ttx_next, tty_next;
    logic signed [50:0]       px_reg, py_reg, px_next, py_next;
    logic signed [ACC_W-1:0]  a1_reg;

    // Stage 2: first hash mix, fade, remapped coordinates.
    ctl_t                     c2_reg;
    logic [31:0]              h1_reg [4];
    logic [31:0]              h1_next [4];
    logic [16:0]              sx_reg, sy_reg, sx_next, sy_next;
    logic [31:0]              nx_reg, ny_reg, nx_next, ny_next;
    logic signed [ACC_W-1:0]  a2_reg;

    // Stage 3: second hash mix.
    ctl_t                     c3_reg;
    logic [31:0]              h2_reg [4];
    logic [31:0]              h2_next [4];
    logic [16:0]              sx3_reg, sy3_reg;
    logic [31:0]              nx3_reg, ny3_reg;
    logic signed [ACC_W-1:0]  a3_reg;

    // Stage 4: corner values.
    ctl_t                     c4_reg;
    logic signed [24:0]       cv_reg [4];
    logic signed [24:0]       cv_next [4];
    logic [16:0]              sx4_reg, sy4_reg;
    logic [31:0]              nx4_reg, ny4_reg;
    logic signed [ACC_W-1:0]  a4_reg;

    // Stage 5: blend along x.
    ctl_t                     c5_reg;
    logic signed [V_W-1:0]    ab_reg, cd_reg, ab_next, cd_next;
    logic [16:0]              sy5_reg;
    logic [31:0]              nx5_reg, ny5_reg;
    logic signed [ACC_W-1:0]  a5_reg;

    // Stage 6: blend along y.
    ctl_t                     c6_reg;
    logic signed [V_W-1:0]    v_reg, v_next;
    logic [31:0]              nx6_reg, ny6_reg;
    logic signed [ACC_W-1:0]  a6_reg;

    // Stage 7: octave sum.
    ctl_t                     c7_reg;
    logic [31:0]              nx7_reg, ny7_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic [31:0]    ix, iy, ix1, iy1, seed_k;
    logic [31:0]    hx [4];
    logic [31:0]    hy [4];
    logic [F+15:0]  fx_wide, fy_wide;

    always_comb
    begin
        ix = $unsigned($signed(x_i) >>> F);
        iy = $unsigned($signed(y_i) >>> F);
        ix1 = ix + 32'd1;
        iy1 = iy + 32'd1;
        seed_k = seed + SEED_OFS;
        hx[0] = ix;  hy[0] = iy;
        hx[1] = ix1; hy[1] = iy;
        hx[2] = ix;  hy[2] = iy1;
        hx[3] = ix1; hy[3] = iy1;
        for (int j = 0; j < 4; j++)
        begin
            h0_next[j] = (hx[j] * HASH_MUL_X) ^ (hy[j] * HASH_MUL_Y) ^ (seed_k * HASH_MUL_S);
        end
        fx_wide = {x_i[F-1:0], 16'd0};
        fy_wide = {y_i[F-1:0], 16'd0};
        tx_next = fx_wide[F+15:F];
        ty_next = fy_wide[F+15:F];
        ttx_next = 32'(tx_next) * 32'(tx_next);
        tty_next = 32'(ty_next) * 32'(ty_next);
        px_next = $signed(x_i) * GAIN_Q16;
        py_next = $signed(y_i) * GAIN_Q16;
        c1_next = ctl_i;
    end

    logic [17:0]        kx, ky;
    logic [49:0]        fpx, fpy;
    logic signed [50:0] prx, pry;
    logic [31:0]        hm1 [4];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            hm1[j] = h0_reg[j] ^ (h0_reg[j] >> 16);
            h1_next[j] = hm1[j] * HASH_MIX_A;
        end
        // Smoothstep: t*t*(3 - 2t) with rounding.
        kx = 18'd196608 - {1'b0, tx_reg, 1'b0};
        ky = 18'd196608 - {1'b0, ty_reg, 1'b0};
        fpx = 50'(ttx_reg) * 50'(kx) + 50'h0_8000_0000;
        fpy = 50'(tty_reg) * 50'(ky) + 50'h0_8000_0000;
        sx_next = fpx[48:32];
        sy_next = fpy[48:32];
        prx = px_reg + 51'sd32768;
        pry = py_reg + 51'sd32768;
        nx_next = prx[47:16] + OFFSET_X;
        ny_next = pry[47:16] - OFFSET_Y;
    end

    logic [31:0] hm2 [4];
    logic [31:0] hm3 [4];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            hm2[j] = h1_reg[j] ^ (h1_reg[j] >> 15);
            h2_next[j] = hm2[j] * HASH_MIX_B;
            hm3[j] = h2_reg[j] ^ (h2_reg[j] >> 16);
            cv_next[j] = $signed({1'b0, hm3[j][23:0]}) - $signed({2'b00, HALF_SPAN});
        end
    end

    logic signed [25:0] dab, dcd;
    logic signed [43:0] pab, pcd;
    logic signed [27:0] abw, cdw;
    logic signed [26:0] dv;
    logic signed [44:0] pv;
    logic signed [28:0] vw;

    always_comb
    begin
        dab = 26'(cv_reg[1]) - 26'(cv_reg[0]);
        dcd = 26'(cv_reg[3]) - 26'(cv_reg[2]);
        pab = dab * $signed({1'b0, sx4_reg}) + 44'sd32768;
        pcd = dcd * $signed({1'b0, sx4_reg}) + 44'sd32768;
        abw = 28'(cv_reg[0]) + $signed(pab[43:16]);
        cdw = 28'(cv_reg[2]) + $signed(pcd[43:16]);
        ab_next = abw[V_W-1:0];
        cd_next = cdw[V_W-1:0];

        dv = 27'(cd_reg) - 27'(ab_reg);
        pv = dv * $signed({1'b0, sy5_reg}) + 45'sd32768;
        vw = 29'(ab_reg) + $signed(pv[44:16]);
        v_next = vw[V_W-1:0];

        // Earlier octaves carry the larger weights: acc = 2*acc + v in octaves below the count; later ones pass acc on.
        if (OCTN_W'(OCT_IDX) < c6_reg.octaves)
        begin
            acc_next = (a6_reg <<< 1) + ACC_W'(v_reg);
        end
        else
        begin
            acc_next = a6_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
            c7_reg <= '0;
        end
        else if (en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
            c5_reg <= c4_reg;
            c6_reg <= c5_reg;
            c7_reg <= c6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h0_reg  <= h0_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            ttx_reg <= ttx_next;
            tty_reg <= tty_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
            a1_reg  <= acc_i;

            h1_reg  <= h1_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            a2_reg  <= a1_reg;

            h2_reg  <= h2_next;
            sx3_reg <= sx_reg;
            sy3_reg <= sy_reg;
            nx3_reg <= nx_reg;
            ny3_reg <= ny_reg;
            a3_reg  <= a2_reg;

            cv_reg  <= cv_next;
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
            nx4_reg <= nx3_reg;
            ny4_reg <= ny3_reg;
            a4_reg  <= a3_reg;

            ab_reg  <= ab_next;
            cd_reg  <= cd_next;
            sy5_reg <= sy4_reg;
            nx5_reg <= nx4_reg;
            ny5_reg <= ny4_reg;
            a5_reg  <= a4_reg;

            v_reg   <= v_next;
            nx6_reg <= nx5_reg;
            ny6_reg <= ny5_reg;
            a6_reg  <= a5_reg;

            acc_reg <= acc_next;
            nx7_reg <= nx6_reg;
            ny7_reg <= ny6_reg;
        end
    end

    assign ctl_o = c7_reg;
    assign x_o   = nx7_reg;
    assign y_o   = ny7_reg;
    assign acc_o = acc_reg;

endmodule

// File: src/vnfbm_div.sv
module vnfbm_div #(
    parameter int MAX_OCTAVES = 8,
    parameter int ACC_W       = 35
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  vnfbm_pkg::ctl_t                      ctl_i,
    input  logic signed [ACC_W-1:0]              acc_i,
    output vnfbm_pkg::ctl_t                      ctl_o,
    output logic signed [vnfbm_pkg::NOISE_W-1:0] q_o
);
    import vnfbm_pkg::*;

    localparam int D_W = 23 + MAX_OCTAVES;
    localparam int R_W = ACC_W + 16;
    localparam int QB  = 15;

    // Prepare stage: magnitude, rounding bias and divisor.
    ctl_t            cp_reg;
    logic [R_W-1:0]  rp_reg, rp_next;
    logic [D_W-1:0]  dp_reg, dp_next;
    logic            np_reg;
    logic [ACC_W-1:0] mag;

    always_comb
    begin
        mag = acc_i[ACC_W-1] ? $unsigned(-acc_i) : $unsigned(acc_i);
        dp_next = (D_W'(HALF_SPAN) << ctl_i.octaves) - D_W'(HALF_SPAN);
        rp_next = (R_W'(mag) << QB) + R_W'(dp_next >> 1);
    end

    // Restoring divider, one quotient bit per stage.
    ctl_t            c_reg [QB+1];
    logic [R_W-1:0]  r_reg [QB+1];
    logic [D_W-1:0]  d_reg [QB+1];
    logic [QB:0]     q_reg [QB+1];
    logic            n_reg [QB+1];
    logic [R_W-1:0]  r_next [QB+1];
    logic [QB:0]     q_next [QB+1];
    logic [R_W-1:0]  dsh [QB+1];

    always_comb
    begin
        // Anything at or above 32768 saturates; the low bits are then ignored.
        dsh[0] = R_W'(dp_reg) << QB;
        q_next[0] = '0;
        q_next[0][QB] = (rp_reg >= dsh[0]);
        r_next[0] = rp_reg;
        for (int g = 1; g <= QB; g++)
        begin
            dsh[g] = R_W'(d_reg[g-1]) << (QB - g);
            q_next[g] = q_reg[g-1];
            r_next[g] = r_reg[g-1];
            if (r_reg[g-1] >= dsh[g])
            begin
                r_next[g] = r_reg[g-1] - dsh[g];
                q_next[g][QB-g] = 1'b1;
            end
        end
    end

    ctl_t                      co_reg;
    logic signed [NOISE_W-1:0] qo_reg, qo_next;
    logic [QB:0]               qf;

    always_comb
    begin
        qf = q_reg[QB];
        if (c_reg[QB].octaves == '0)
        begin
            qo_next = '0;
        end
        else if (qf[QB])
        begin
            qo_next = n_reg[QB] ? 16'sh8000 : 16'sh7fff;
        end
        else if (n_reg[QB])
        begin
            qo_next = -$signed(qf);
        end
        else
        begin
            qo_next = $signed(qf);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg <= '0;
            co_reg <= '0;
            for (int g = 0; g <= QB; g++)
            begin
                c_reg[g] <= '0;
            end
        end
        else if (en)
        begin
            cp_reg <= ctl_i;
            c_reg[0] <= cp_reg;
            for (int g = 1; g <= QB; g++)
            begin
                c_reg[g] <= c_reg[g-1];
            end
            co_reg <= c_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp_reg <= rp_next;
            dp_reg <= dp_next;
            np_reg <= acc_i[ACC_W-1];
            r_reg[0] <= r_next[0];
            q_reg[0] <= q_next[0];
            d_reg[0] <= dp_reg;
            n_reg[0] <= np_reg;
            for (int g = 1; g <= QB; g++)
            begin
                r_reg[g] <= r_next[g];
                q_reg[g] <= q_next[g];
                d_reg[g] <= d_reg[g-1];
                n_reg[g] <= n_reg[g-1];
            end
            qo_reg <= qo_next;
        end
    end

    assign ctl_o = co_reg;
    assign q_o   = qo_reg;

endmodule

// File: src/value_noise_fbm_2d_core.sv
// Channel    Direction  Word                          Accepted when
// sample_in  in         coord_x, coord_y (Q16.16)     valid && ready
// noise_out  out        noise_value (Q1.15)           valid && ready
// cfg        in         index, data                   valid && ready (ready is always high)
//
// One word enters per cycle unless the output stalls; a result passes through
// seven stages per octave unit, then the sixteen-step restoring divider with
// its prepare and output stages.
// Reset clears all valid bits and loads seed 4171 and four octaves.
// The whole pipeline moves together: it advances whenever the output register
// is empty or being read, so a stall freezes every stage and loses nothing.
module value_noise_fbm_2d_core #(
    parameter int MAX_OCTAVES     = 8,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    vnfbm_coord_if.sink    sample_in,
    vnfbm_noise_if.source  noise_out,
    vnfbm_cfg_if.sink      cfg
);
    import vnfbm_pkg::*;

    // Accumulator holds sum of v_k * 2^(n-1-k) with one spare bit.
    localparam int ACC_W = V_W + MAX_OCTAVES + 1;

    // Configuration registers. The user must change them only while the block is idle;
    // the block itself does not enforce this, and every stage reads them directly.
    logic [SEED_W-1:0] noise_seed_reg, noise_seed_next;
    logic [OCT_W-1:0]  octave_count_reg, octave_count_next;

    always_comb
    begin
        noise_seed_next = noise_seed_reg;
        octave_count_next = octave_count_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_NOISE_SEED:   noise_seed_next = cfg.data[SEED_W-1:0];
                REG_OCTAVE_COUNT: octave_count_next = cfg.data[OCT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_seed_reg <= SEED_RESET;
            octave_count_reg <= OCTAVE_RESET;
        end
        else
        begin
            noise_seed_reg <= noise_seed_next;
            octave_count_reg <= octave_count_next;
        end
    end

    assign cfg.ready = 1'b1;

    // Global advance: the output register is free or is being emptied.
    ctl_t out_ctl;
    logic en;

    assign en = !out_ctl.valid || noise_out.ready;
    assign sample_in.ready = en;

    // Links between octave units; link 0 is the incoming word.
    ctl_t                    link_ctl [MAX_OCTAVES+1];
    logic [COORD_W-1:0]      link_x   [MAX_OCTAVES+1];
    logic [COORD_W-1:0]      link_y   [MAX_OCTAVES+1];
    logic signed [ACC_W-1:0] link_acc [MAX_OCTAVES+1];

    // Octave counts above the build limit run the full chain.
    always_comb
    begin
        link_ctl[0].valid = sample_in.valid;
        if ({1'b0, octave_count_reg} > OCTN_W'(MAX_OCTAVES))
        begin
            link_ctl[0].octaves = OCTN_W'(MAX_OCTAVES);
        end
        else
        begin
            link_ctl[0].octaves = {1'b0, octave_count_reg};
        end
        link_x[0] = $unsigned(sample_in.coord_x);
        link_y[0] = $unsigned(sample_in.coord_y);
        link_acc[0] = '0;
    end

    // One unit per octave; each remaps the coordinates for the next one.
    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        vnfbm_octave #(
            .OCT_IDX         (k),
            .COORD_FRAC_BITS (COORD_FRAC_BITS),
            .ACC_W           (ACC_W)
        ) u_octave (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .seed  (noise_seed_reg),
            .ctl_i (link_ctl[k]),
            .x_i   (link_x[k]),
            .y_i   (link_y[k]),
            .acc_i (link_acc[k]),
            .ctl_o (link_ctl[k+1]),
            .x_o   (link_x[k+1]),
            .y_o   (link_y[k+1]),
            .acc_o (link_acc[k+1])
        );
    end

    // Normalization by the amplitude total and Q1.15 saturation.
    logic signed [NOISE_W-1:0] out_q;

    vnfbm_div #(
        .MAX_OCTAVES (MAX_OCTAVES),
        .ACC_W       (ACC_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ctl_i (link_ctl[MAX_OCTAVES]),
        .acc_i (link_acc[MAX_OCTAVES]),
        .ctl_o (out_ctl),
        .q_o   (out_q)
    );

    assign noise_out.valid = out_ctl.valid;
    assign noise_out.noise_value = out_q;

`ifndef SYNTHESIS
    // A word built with no octaves must come out as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ctl.valid && out_ctl.octaves == '0 |-> out_q == '0)
        else $error("zero-octave word gave a nonzero result");

    // The input is held off only while a finished word waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !sample_in.ready |-> noise_out.valid && !noise_out.ready)
        else $error("input stalled without a blocked output");

    // An octave count write lands in the register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && cfg.index == REG_OCTAVE_COUNT
        |=> octave_count_reg == $past(cfg.data[OCT_W-1:0]))
        else $error("octave count write lost");
`endif

endmodule

// File: tb/vnfbm_checker.sv
`timescale 1ns / 1ps

module vnfbm_checker
    import vnfbm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    vnfbm_coord_if             sample_in,
    vnfbm_noise_if             noise_out,
    vnfbm_cfg_if               cfg,
    output int                 fail_count,
    output int                 pending
);

    localparam int MAX_OCT   = 8;
    localparam int FRAC_BITS = 16;

    logic [SEED_W-1:0] seed_q;
    logic [OCT_W-1:0]  octaves_q;
    logic signed [NOISE_W-1:0] noise_expected_q[$];

    function automatic longint fdiv(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic logic [31:0] lattice_mix(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] s);
        logic [31:0] h;
        h = (x * HASH_MUL_X) ^ (y * HASH_MUL_Y) ^ (s * HASH_MUL_S);
        h = h ^ (h >> 16);
        h = h * HASH_MIX_A;
        h = h ^ (h >> 15);
        h = h * HASH_MIX_B;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic longint corner_val(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] s);
        logic [31:0] h;
        h = lattice_mix(x, y, s);
        return longint'({8'd0, h[23:0]}) - longint'(HALF_SPAN);
    endfunction

    function automatic longint smooth_fade(input logic [31:0] c);
        longint unsigned t;
        longint unsigned k;
        t = longint'(c[FRAC_BITS-1:0]);
        k = 3 * 65536 - 2 * t;
        return longint'((t * t * k + 64'h8000_0000) >> 32);
    endfunction

    function automatic longint lerp16(input longint a, input longint b, input longint s);
        return a + fdiv((b - a) * s + 32768, 16);
    endfunction

    function automatic longint cell_noise(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] s);
        logic [31:0] ix;
        logic [31:0] iy;
        longint fx, fy, ab, cd;
        ix = 32'(fdiv(longint'($signed(x)), FRAC_BITS));
        iy = 32'(fdiv(longint'($signed(y)), FRAC_BITS));
        fx = smooth_fade(x);
        fy = smooth_fade(y);
        ab = lerp16(corner_val(ix, iy, s), corner_val(ix + 32'd1, iy, s), fx);
        cd = lerp16(corner_val(ix, iy + 32'd1, s), corner_val(ix + 32'd1, iy + 32'd1, s), fx);
        return lerp16(ab, cd, fy);
    endfunction

    function automatic logic [31:0] stretch(input logic [31:0] c);
        return 32'(fdiv(longint'($signed(c)) * 133038 + 32768, 16));
    endfunction

    function automatic logic signed [NOISE_W-1:0] fbm_sample(input logic [31:0] x0,
                                                            input logic [31:0] y0);
        logic [31:0] x, y, offs_x, offs_y;
        int n;
        longint acc, num, den, q;
        longint unsigned mag;
        x = x0;
        y = y0;
        n = octaves_q;
        acc = 0;
        offs_x = 32'(((64'd717 << FRAC_BITS) + 50) / 100);
        offs_y = 32'(((64'd341 << FRAC_BITS) + 50) / 100);
        if (n == 0)
            return '0;
        if (n > MAX_OCT)
            n = MAX_OCT;
        for (int k = 0; k < n; k++)
        begin
            acc += cell_noise(x, y, seed_q + 32'(k) * SEED_STEP) * (64'sd1 <<< (n - 1 - k));
            x = stretch(x) + offs_x;
            y = stretch(y) - offs_y;
        end
        num = acc * 32768;
        den = ((64'sd1 <<< n) - 1) * longint'(HALF_SPAN);
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        q = (num < 0) ? -longint'(mag) : longint'(mag);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    assign pending = noise_expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [NOISE_W-1:0] want;
        if (!rst_n)
        begin
            seed_q     <= SEED_RESET;
            octaves_q  <= OCTAVE_RESET;
            fail_count <= 0;
            noise_expected_q.delete();
        end
        else
        begin
            if (sample_in.valid && sample_in.ready)
                noise_expected_q = {noise_expected_q,
                                    fbm_sample(sample_in.coord_x, sample_in.coord_y)};
            if (noise_out.valid && noise_out.ready)
            begin
                if (noise_expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected noise word %0d", noise_out.noise_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = noise_expected_q.pop_front();
                    if (want !== noise_out.noise_value)
                    begin
                        if (fail_count < 10)
                            $display("noise_value expected %0d got %0d", want,
                                     noise_out.noise_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Register writes take effect for words accepted after this edge.
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_NOISE_SEED)
                    seed_q <= cfg.data;
                else if (cfg.index == REG_OCTAVE_COUNT)
                    octaves_q <= cfg.data[OCT_W-1:0];
            end
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import vnfbm_pkg::*;

    // The block takes one coordinate word per cycle unless the output stalls, and
    // returns one noise word for each. The checker predicts every word; this module
    // only drives the channels, moves through register settings and gives the verdict.
    localparam int LATENCY   = 7 * 8 + 18;
    localparam int WATCHDOG  = 20000;
    localparam int RAND_ITEMS = 1230;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   calm;

    vnfbm_coord_if sample_in ();
    vnfbm_noise_if noise_out ();
    vnfbm_cfg_if   cfg ();

    value_noise_fbm_2d_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .noise_out (noise_out),
        .cfg       (cfg)
    );

    vnfbm_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .noise_out  (noise_out),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // The receiver stalls in random bursts until the final stretch of the run.
    initial
    begin
        noise_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                noise_out.ready <= 1'b0;
                repeat ($urandom_range(1, 15))
                    @(posedge clk);
            end
            noise_out.ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which no word moves on any channel.
    always @(posedge clk)
    begin
        if ((sample_in.valid && sample_in.ready) || (noise_out.valid && noise_out.ready)
            || (cfg.valid && cfg.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("value_noise_fbm_2d_core: mismatch");
            $finish;
        end
    end

    // Sends one coordinate word and waits until it is taken.
    task automatic send_sample(input logic [31:0] x, input logic [31:0] y);
        if (!calm && $urandom_range(0, 11) == 0)
        begin
            sample_in.valid <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge clk);
        end
        sample_in.valid   <= 1'b1;
        sample_in.coord_x <= x;
        sample_in.coord_y <= y;
        @(posedge clk);
        while (!sample_in.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        sample_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Registers are written only with the pipeline empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h3ff_ffff)) - 32'sh200_0000);
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return 32'($urandom_range(0, 1) ? 32'h7fff_0000 : 32'h8000_0000)
                            + 32'($urandom_range(0, 32'h1_ffff));
        endcase
    endfunction

    initial
    begin
        logic [31:0] edge_vals[8];
        int n;
        edge_vals = '{32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                      32'h0000_ffff, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000};
        calm = 1'b0;
        sample_in.valid = 1'b0;
        sample_in.coord_x = '0;
        sample_in.coord_y = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings: field extremes and lattice edges,
        // where the neighbour cell index wraps around.
        for (int i = 0; i < 8; i++)
            send_sample(edge_vals[i], edge_vals[7 - i]);
        send_sample(32'h7fff_ffff, 32'h7fff_ffff);
        send_sample(32'h8000_0000, 32'h8000_0000);

        // Zero octaves gives silence; above the maximum is clamped; an index
        // beyond the register list is ignored.
        write_reg(REG_OCTAVE_COUNT, 32'd0);
        send_sample(32'h1234_5678, 32'h9abc_def0);
        send_sample(32'hffff_ffff, 32'h0);
        write_reg(REG_OCTAVE_COUNT, 32'd15);
        send_sample(32'h0003_8000, 32'hfffc_4000);
        send_sample(32'h8000_0000, 32'h7fff_ffff);
        write_reg(4'd9, 32'h5);
        write_reg(REG_OCTAVE_COUNT, 32'd1);
        write_reg(REG_NOISE_SEED, 32'h8000_0000);
        for (int i = 0; i < 4; i++)
            send_sample(edge_vals[i], edge_vals[i + 4]);
        write_reg(REG_NOISE_SEED, 32'h7fff_ffff);
        write_reg(REG_OCTAVE_COUNT, 32'd8);
        for (int i = 0; i < 4; i++)
            send_sample(edge_vals[i + 4], edge_vals[i]);

        // Random phases, each with its own settings; the final phase runs
        // without any stalls on either side.
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase == 9)
                calm = 1'b1;
            write_reg(REG_NOISE_SEED, $urandom());
            n = (phase == 0) ? 8 : (phase == 1) ? 1 : $urandom_range(0, 15);
            write_reg(REG_OCTAVE_COUNT, n);
            for (int i = 0; i < RAND_ITEMS / 10; i++)
                send_sample(rand_coord(), rand_coord());
        end

        drain();
        repeat (LATENCY + 20)
            @(posedge clk);
        if (fail_count == 0)
            $display("value_noise_fbm_2d_core: match");
        else
            $display("value_noise_fbm_2d_core: mismatch");
        $finish;
    end

endmodule

// File: sim.f
src/vnfbm_pkg.sv
src/vnfbm_coord_if.sv
src/vnfbm_noise_if.sv
src/vnfbm_cfg_if.sv
src/vnfbm_octave.sv
src/vnfbm_div.sv
src/value_noise_fbm_2d_core.sv
tb/vnfbm_checker.sv
tb/tb.sv
